### hdl/htfd_pkg.sv
`default_nettype none

package htfd_pkg;

  // CRC-8 over each two-byte word: poly 0x31, init 0xFF, MSB first
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Scaling constants, hundredths of a unit
  localparam logic [14:0] TEMP_SPAN_CENTI   = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET_CENTI = 15'd4500;
  localparam logic [14:0] HUM_SPAN_CENTI    = 15'd12500;
  localparam logic [14:0] HUM_OFFSET_CENTI  = 15'd600;
  localparam logic [13:0] HUM_MAX_CENTI     = 14'd10000;
  localparam logic [15:0] FULL_SCALE        = 16'hFFFF;

  // Position of a byte within the six-byte reply
  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5
  } byte_pos_e;

  // One decoded result word
  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic               temperature_ok;
    logic [13:0]        humidity_centi;
    logic               humidity_ok;
  } result_t;

  // Feed one byte into the CRC, eight shift steps
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(x / 65535) for x below 65535 * 2^15: estimate by x*(1 + 2^-16) >> 16,
  // which is exact or one short, then one remainder check
  function automatic logic [14:0] div_full_scale(input logic [30:0] x);
    logic [31:0] sum;
    logic [14:0] q;
    logic [31:0] rem;
    sum = {1'b0, x} + {17'd0, x[30:16]};
    q   = sum[30:16];
    rem = {1'b0, x} - {1'b0, q, 16'd0} + {17'd0, q};
    if (rem >= {16'd0, FULL_SCALE}) begin
      q = q + 15'd1;
    end
    return q;
  endfunction

endpackage

`default_nettype wire

### hdl/htfd_in_reg.sv
`default_nettype none

module htfd_in_reg
  import htfd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       frame_start_i,
  input  wire logic       take_i,
  output logic            valid_o,
  output logic [7:0]      rx_byte_o,
  output logic            frame_start_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       start_q;

  // Held word blocks the port only when the core cannot take it
  assign in_stall_o = valid_q & ~take_i;
  assign valid_d    = in_valid_i | in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload loads whenever the register is free or drains
  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      byte_q  <= rx_byte_i;
      start_q <= frame_start_i;
    end
  end

  assign valid_o       = valid_q;
  assign rx_byte_o     = byte_q;
  assign frame_start_o = start_q;

endmodule

`default_nettype wire

### hdl/htfd_core.sv
`default_nettype none

module htfd_core
  import htfd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       frame_start_i,
  output logic            yields_o,
  output result_t         result_o
);

  logic [2:0]         pos_q, pos_d;
  logic [7:0]         crc_q, crc_d;
  logic [7:0]         hi_q, hi_d;
  logic [30:0]        prod_q, prod_d;
  logic signed [14:0] temp_q, temp_d;
  logic               temp_ok_q, temp_ok_d;

  byte_pos_e   pos;
  logic [7:0]  crc_next;
  logic        crc_match;
  logic [14:0] coeff;
  logic [14:0] quot;
  logic [15:0] temp_diff;
  logic [14:0] hum_diff;
  logic [13:0] hum_val;

  // Start mark or a stray code restarts at the first byte
  always_comb begin
    if (frame_start_i || (pos_q > 3'(POS_H_CRC))) begin
      pos = POS_T_HI;
    end else begin
      pos = byte_pos_e'(pos_q);
    end
  end

  // CRC step and scaling datapath
  always_comb begin
    if (pos == POS_T_HI || pos == POS_H_HI) begin
      crc_next = crc8_feed(CRC_INIT, rx_byte_i);
    end else begin
      crc_next = crc8_feed(crc_q, rx_byte_i);
    end
    crc_match = (crc_q == rx_byte_i);
    coeff     = (pos == POS_T_LO) ? TEMP_SPAN_CENTI : HUM_SPAN_CENTI;
    quot      = div_full_scale(prod_q);
    temp_diff = {1'b0, quot} - {1'b0, TEMP_OFFSET_CENTI};
    hum_diff  = quot - HUM_OFFSET_CENTI;
    if (quot < HUM_OFFSET_CENTI) begin
      hum_val = '0;
    end else if (hum_diff > {1'b0, HUM_MAX_CENTI}) begin
      hum_val = HUM_MAX_CENTI;
    end else begin
      hum_val = hum_diff[13:0];
    end
  end

  // State update per byte position
  always_comb begin
    crc_d     = crc_q;
    hi_d      = hi_q;
    prod_d    = prod_q;
    temp_d    = temp_q;
    temp_ok_d = temp_ok_q;
    pos_d     = (pos == POS_H_CRC) ? 3'(POS_T_HI) : 3'(pos) + 3'd1;
    unique case (pos)
      POS_T_HI, POS_H_HI: begin
        crc_d = crc_next;
        hi_d  = rx_byte_i;
      end
      POS_T_LO, POS_H_LO: begin
        crc_d  = crc_next;
        prod_d = 31'({hi_q, rx_byte_i}) * 31'(coeff);
      end
      POS_T_CRC: begin
        crc_d     = CRC_INIT;
        temp_ok_d = crc_match;
        temp_d    = crc_match ? $signed(temp_diff[14:0]) : 15'sd0;
      end
      POS_H_CRC: begin
        crc_d = CRC_INIT;
      end
      default: begin
        crc_d = CRC_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= 3'(POS_T_HI);
      crc_q     <= CRC_INIT;
      hi_q      <= '0;
      prod_q    <= '0;
      temp_q    <= '0;
      temp_ok_q <= 1'b0;
    end else if (fire_i) begin
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      hi_q      <= hi_d;
      prod_q    <= prod_d;
      temp_q    <= temp_d;
      temp_ok_q <= temp_ok_d;
    end
  end

  // Result for the humidity CRC byte
  assign yields_o                   = (pos == POS_H_CRC);
  assign result_o.temperature_centi = temp_q;
  assign result_o.temperature_ok    = temp_ok_q;
  assign result_o.humidity_centi    = crc_match ? hum_val : 14'd0;
  assign result_o.humidity_ok       = crc_match;

endmodule

`default_nettype wire

### hdl/htfd_out_reg.sv
`default_nettype none

module htfd_out_reg
  import htfd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t result_i,
  output logic         free_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output result_t      result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  // Free when empty or the held word leaves this cycle
  assign free_o  = ~valid_q | ~out_stall_i;
  assign valid_d = load_i | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

### hdl/humidity_temp_frame_decoder.sv
// Channel | Handshake               | Word
// --------+-------------------------+-----------------------------------------------
// in      | in_valid_i / in_stall_o | rx_byte_i, frame_start_i
// out     | out_valid_o/ out_stall_i| temperature_centi_o, temperature_ok_o,
//         |                         | humidity_centi_o, humidity_ok_o
//
// One byte is taken every cycle while in_stall_o is low; a byte passes an
// input register, then the CRC, multiply and scaling logic, and the sixth byte
// writes the output register, whose valid flag drives out_valid_o.
// Reset clears the byte position and CRC; the first byte after reset is position 0.
// A stalled output holds its word; bytes keep flowing until the sixth byte of the
// next reply meets a full output register.
`default_nettype none

module humidity_temp_frame_decoder
  import htfd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        frame_start_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [14:0] temperature_centi_o,
  output logic             temperature_ok_o,
  output logic [13:0]      humidity_centi_o,
  output logic             humidity_ok_o
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_start;
  logic       take;
  logic       fire;
  logic       yields;
  logic       out_free;
  result_t    core_result;
  result_t    out_result;

  htfd_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .take_i        (take),
    .valid_o       (s1_valid),
    .rx_byte_o     (s1_byte),
    .frame_start_o (s1_start)
  );

  // A byte that makes no result never waits on the output side
  assign take = ~yields | out_free;
  assign fire = s1_valid & take;

  htfd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .rx_byte_i     (s1_byte),
    .frame_start_i (s1_start),
    .yields_o      (yields),
    .result_o      (core_result)
  );

  htfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire & yields),
    .result_i    (core_result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign temperature_centi_o = out_result.temperature_centi;
  assign temperature_ok_o    = out_result.temperature_ok;
  assign humidity_centi_o    = out_result.humidity_centi;
  assign humidity_ok_o       = out_result.humidity_ok;

endmodule

`default_nettype wire
